### sv/rgb_soft_pwm_blink_patterns_defines.svh
// assertion macros shared by the rgb pwm block
`ifndef RGB_SOFT_PWM_BLINK_PATTERNS_DEFINES_SVH
`define RGB_SOFT_PWM_BLINK_PATTERNS_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define RSPB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rspb check failed");

// consequent must hold in the cycle after the antecedent
`define RSPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rspb check failed");

`endif

### sv/rspb_pkg.sv
package rspb_pkg;

  localparam int unsigned PWM_LEN_DEF = 32;
  localparam int unsigned CntW        = 8;
  localparam int unsigned SlowW       = 7;
  localparam int unsigned PhaseW      = 4;
  localparam int unsigned NumLed      = 3;

  localparam logic [SlowW-1:0]  SLOW_RESET  = 7'd100;
  localparam logic [SlowW-1:0]  SLOW_RELOAD = 7'd90;
  localparam logic [PhaseW-1:0] PHASE_TOP   = 4'd11;
  localparam logic [PhaseW-1:0] PHASE_HALF  = 4'd6;

  // duty levels used by the patterns
  localparam logic [CntW-1:0] DUTY_MIN  = 8'd1;
  localparam logic [CntW-1:0] DUTY_LOW  = 8'd2;
  localparam logic [CntW-1:0] DUTY_MID  = 8'd4;
  localparam logic [CntW-1:0] DUTY_HIGH = 8'd10;
  localparam logic [CntW-1:0] RAMP_TOP  = 8'd6;
  localparam logic [CntW-1:0] TRI_TOP   = 8'd12;

  // pattern modes
  localparam logic [7:0] MODE_PHASE0  = 8'd0;
  localparam logic [7:0] MODE_BLIP    = 8'd1;
  localparam logic [7:0] MODE_FLASH   = 8'd2;
  localparam logic [7:0] MODE_FLASH_D = 8'd3;
  localparam logic [7:0] MODE_GLOW    = 8'd4;
  localparam logic [7:0] MODE_STROBE  = 8'd5;
  localparam logic [7:0] MODE_RAMP    = 8'd6;
  localparam logic [7:0] MODE_TRI     = 8'd7;
  localparam logic [7:0] MODE_ALT     = 8'd10;

  // configuration register indexes
  localparam logic CFG_TEAM_MASK  = 1'b0;
  localparam logic CFG_BLINK_MODE = 1'b1;

  // item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

endpackage

### sv/rgb_soft_pwm_blink_patterns.sv
// three-channel software pwm led driver with a slow blink pattern sequencer
//
// input channel: in_valid_i / in_stall_o with op_i, override_mode_i and
// override_steps_i; a transfer happens when valid is high and stall is low.
// op tick advances the pwm counter and the pattern divider, op load stores
// an override mode and its length in slow steps.
// output channel: out_valid_o / out_stall_i with led_bits_o, one result per
// accepted item, the led levels after that item.
// config: cfg_valid_i / cfg_ready_o, index 0 team_mask, index 1 blink_mode;
// ready is always high, write only while the block is idle.
//
// all the work for an item is done in the cycle it is accepted; the result
// is registered in the output or skid register. one item per cycle while
// in_stall_o is low. a two-entry output stage (output register plus skid
// register) lets an item be taken while a result waits; in_stall_o rises
// only once the skid register is full, and it depends on registers alone.
// reset puts PwmMax in the pwm counter and SLOW_RESET in the divider, clears
// phase, duties, override, both output entries; team_mask 0, blink_mode 1.
module rgb_soft_pwm_blink_patterns import rspb_pkg::*; #(
  parameter int unsigned PwmLen = PWM_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [7:0]       override_mode_i,
  input  logic [7:0]       override_steps_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [NumLed-1:0] led_bits_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [7:0]       cfg_data_i
);

  `include "rgb_soft_pwm_blink_patterns_defines.svh"

  localparam logic [CntW-1:0] PwmMax  = CntW'(PwmLen - 1);
  localparam logic [CntW-1:0] DutyFul = CntW'(PwmLen);

  typedef logic [NumLed-1:0][CntW-1:0] duty_t;

  logic [CntW-1:0]   pwm_q;
  logic [SlowW-1:0]  slow_q;
  logic [PhaseW-1:0] phase_q;
  duty_t             duty_q;
  logic [7:0]        ovr_mode_q, ovr_left_q;
  logic [NumLed-1:0] led_q;
  logic [2:0]        team_mask_q;
  logic [7:0]        blink_mode_q;

  logic              out_valid_q, skid_valid_q;
  logic [NumLed-1:0] out_q, skid_q;

  logic              in_acc, out_take;
  logic [CntW-1:0]   pwm_d;
  logic [NumLed-1:0] bits_d, result_d;
  logic [SlowW-1:0]  slow_dec, slow_d;
  logic              fire;
  logic [PhaseW-1:0] phase_d;
  logic [7:0]        mode_sel;
  duty_t             duty_d;

  function automatic duty_t team_on(logic [2:0] mask, logic [CntW-1:0] lvl);
    duty_t d;
    for (int i = 0; i < NumLed; i++) begin
      d[i] = mask[i] ? lvl : '0;
    end
    return d;
  endfunction

  function automatic duty_t pattern(logic [7:0] mode, logic [PhaseW-1:0] p,
                                    logic [2:0] mask);
    duty_t d;
    logic  p_six;
    logic  p_low;
    d     = '0;
    p_six = (p == '0) || (p == PHASE_HALF);
    p_low = (p < PHASE_HALF);
    unique case (mode)
      MODE_PHASE0: if (p == '0) d = team_on(mask, DUTY_MIN);
      MODE_BLIP:   if (p_six) d = team_on(mask, DUTY_MIN);
      MODE_FLASH:  if (p_six) d = team_on(mask, DutyFul);
      MODE_GLOW:   d = team_on(mask, p_six ? DUTY_HIGH : DUTY_MID);
      MODE_STROBE: begin
        if (!p[0] && p_low) d = {NumLed{DutyFul}};
        else d = team_on(mask, DUTY_MID);
      end
      MODE_RAMP: begin
        if (p_low) d = team_on(mask, CntW'(p >> 1));
        else d = team_on(mask, RAMP_TOP - CntW'(p >> 1));
      end
      MODE_TRI: begin
        if (p_low) d = team_on(mask, CntW'(p) + 8'd1);
        else d = team_on(mask, TRI_TOP - CntW'(p));
      end
      MODE_ALT: begin
        if (p[0]) begin
          d = {NumLed{DutyFul}};
        end else begin
          // team values of three or more select no channel
          for (int i = 0; i < NumLed; i++) begin
            d[i] = (mask == 3'(i)) ? DUTY_HIGH : '0;
          end
        end
      end
      default: d = team_on(mask, p_six ? DutyFul : DUTY_LOW);
    endcase
    return d;
  endfunction

  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign led_bits_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    pwm_d = (pwm_q == '0) ? PwmMax : pwm_q - 8'd1;
    for (int i = 0; i < NumLed; i++) begin
      bits_d[i] = duty_q[i] > pwm_d;
    end
    slow_dec = slow_q - 7'd1;
    fire     = (slow_dec == '0);
    slow_d   = fire ? SLOW_RELOAD : slow_dec;
    phase_d  = (phase_q == '0) ? PHASE_TOP : phase_q - 4'd1;
    mode_sel = (ovr_left_q != '0) ? ovr_mode_q : blink_mode_q;
    duty_d   = pattern(mode_sel, phase_d, team_mask_q);
    result_d = (op_i == OP_LOAD) ? led_q : bits_d;
  end

  // pattern state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q      <= PwmMax;
      slow_q     <= SLOW_RESET;
      phase_q    <= '0;
      duty_q     <= '0;
      ovr_mode_q <= '0;
      ovr_left_q <= '0;
      led_q      <= '0;
    end else if (in_acc) begin
      if (op_i == OP_LOAD) begin
        ovr_mode_q <= override_mode_i;
        ovr_left_q <= override_steps_i;
      end else begin
        pwm_q  <= pwm_d;
        led_q  <= bits_d;
        slow_q <= slow_d;
        if (fire) begin
          phase_q <= phase_d;
          duty_q  <= duty_d;
          if (ovr_left_q != '0) ovr_left_q <= ovr_left_q - 8'd1;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      team_mask_q  <= '0;
      blink_mode_q <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TEAM_MASK:  team_mask_q  <= cfg_data_i[2:0];
        CFG_BLINK_MODE: blink_mode_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        out_q        <= skid_q;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
        if (in_acc) out_q <= result_d;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
      skid_q       <= result_d;
    end
  end

  `RSPB_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_q || out_valid_q)
  `RSPB_ASSERT_ALWAYS(a_slow_nonzero, slow_q != '0)
  `RSPB_ASSERT_ALWAYS(a_phase_range, phase_q <= PHASE_TOP)
  `RSPB_ASSERT_NEXT(a_load_keeps_pwm, in_acc && op_i == OP_LOAD, $stable(pwm_q))
  `RSPB_ASSERT_NEXT(a_tick_gives_result, in_acc, out_valid_q)

endmodule

### verif/rspb_led_checker.sv
module rspb_led_checker import rspb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              op_i,
  input  logic [7:0]        override_mode_i,
  input  logic [7:0]        override_steps_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [NumLed-1:0] led_bits_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                slow_steps_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [2:0]        team_mask_q;
  logic [7:0]        blink_mode_q;
  logic [CntW-1:0]   pwm_cnt;
  logic [SlowW-1:0]  div_cnt;
  logic [PhaseW-1:0] phase;
  logic [CntW-1:0]   duty [NumLed];
  logic [7:0]        ovr_mode_q;
  logic [7:0]        ovr_left_q;
  logic [NumLed-1:0] led_q;
  logic [NumLed-1:0] led_levels_due [$];
  int                fails;
  int                pattern_steps;

  task automatic light_team(input logic [CntW-1:0] level);
    for (int i = 0; i < NumLed; i++) begin
      if (team_mask_q[i]) duty[i] = level;
    end
  endtask

  task automatic light_all();
    for (int i = 0; i < NumLed; i++) duty[i] = CntW'(PWM_LEN_DEF);
  endtask

  task automatic slow_pattern_step();
    logic [7:0] m;
    logic [7:0] p;
    m = blink_mode_q;
    phase = (phase == '0) ? PHASE_TOP : phase - 1'b1;
    p = 8'(phase);
    for (int i = 0; i < NumLed; i++) duty[i] = '0;
    if (ovr_left_q != '0) begin
      ovr_left_q = ovr_left_q - 1'b1;
      m = ovr_mode_q;
    end
    case (m)
      MODE_PHASE0: if (p == 8'd0) light_team(DUTY_MIN);
      MODE_BLIP:   if (p % PHASE_HALF == 0) light_team(DUTY_MIN);
      MODE_FLASH:  if (p % PHASE_HALF == 0) light_team(CntW'(PWM_LEN_DEF));
      MODE_GLOW: begin
        light_team(DUTY_MID);
        if (p % PHASE_HALF == 0) light_team(DUTY_HIGH);
      end
      MODE_STROBE: begin
        if (!p[0] && p < PHASE_HALF) light_all();
        else light_team(DUTY_MID);
      end
      MODE_RAMP: begin
        if (p < PHASE_HALF) light_team(CntW'(p / 2));
        else light_team(RAMP_TOP - CntW'(p / 2));
      end
      MODE_TRI: begin
        if (p < PHASE_HALF) light_team(p + 8'd1);
        else light_team(TRI_TOP - p);
      end
      MODE_ALT: begin
        // odd phases light everything, even phases one channel picked by the team value
        if (p[0]) light_all();
        else if (team_mask_q < 3'd3) duty[team_mask_q[1:0]] = DUTY_HIGH;
      end
      // flash with dim base, also taken by every unknown mode
      default: begin
        light_team(DUTY_LOW);
        if (p % PHASE_HALF == 0) light_team(CntW'(PWM_LEN_DEF));
      end
    endcase
  endtask

  task automatic run_tick();
    logic [NumLed-1:0] bits;
    pwm_cnt = (pwm_cnt == '0) ? CntW'(PWM_LEN_DEF - 1) : pwm_cnt - 1'b1;
    bits = '0;
    for (int i = 0; i < NumLed; i++) begin
      if (duty[i] > pwm_cnt) bits[i] = 1'b1;
    end
    led_q = bits;
    // leds use the duties from before the pattern update
    div_cnt = div_cnt - 1'b1;
    if (div_cnt == '0) begin
      div_cnt = SLOW_RELOAD;
      slow_pattern_step();
      pattern_steps++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [NumLed-1:0] due;
    if (!rst_ni) begin
      team_mask_q = '0;
      blink_mode_q = MODE_BLIP;
      pwm_cnt = CntW'(PWM_LEN_DEF - 1);
      div_cnt = SLOW_RESET;
      phase = '0;
      for (int i = 0; i < NumLed; i++) duty[i] = '0;
      ovr_mode_q = '0;
      ovr_left_q = '0;
      led_q = '0;
      led_levels_due.delete();
      fails = 0;
      pattern_steps = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      slow_steps_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TEAM_MASK:  team_mask_q = cfg_data_i[2:0];
          CFG_BLINK_MODE: blink_mode_q = cfg_data_i;
          default: ;
        endcase
      end
      // retire before predicting: a result never belongs to the same-cycle transfer
      if (out_valid_i && !out_stall_i) begin
        if (led_levels_due.size() == 0) begin
          $display("%0t: unexpected led_bits, expected none, got %b", $time, led_bits_i);
          fails++;
        end else begin
          due = led_levels_due.pop_front();
          if (led_bits_i !== due) begin
            $display("%0t: led_bits mismatch, expected %b, got %b", $time, due, led_bits_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_LOAD) begin
          ovr_mode_q = override_mode_i;
          ovr_left_q = override_steps_i;
        end else begin
          run_tick();
        end
        led_levels_due.push_back(led_q);
      end
      fail_count_o <= fails;
      pending_o <= led_levels_due.size();
      slow_steps_o <= pattern_steps;
    end
  end

endmodule

### verif/tb_top.sv
module tb_top import rspb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 500000;
  localparam int ItemsPerSetting = 195;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              op_i = OP_TICK;
  logic [7:0]        override_mode_i = '0;
  logic [7:0]        override_steps_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [NumLed-1:0] led_bits_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = CFG_TEAM_MASK;
  logic [7:0]        cfg_data_i = '0;

  int   fail_count;
  int   pending;
  int   slow_steps;
  int   cycles = 0;
  int   stall_left = 0;
  int   ticks_sent = 0;
  int   loads_sent = 0;
  int   settings_used = 0;
  logic quiet = 1'b0;

  logic [2:0] mask_plan [8] = '{3'd0, 3'd7, 3'd2, 3'd5, 3'd7, 3'd1, 3'd6, 3'd4};
  logic [7:0] mode_plan [8] = '{MODE_BLIP, MODE_ALT, MODE_ALT, 8'hFF,
                                MODE_STROBE, MODE_RAMP, MODE_TRI, MODE_ALT};

  rgb_soft_pwm_blink_patterns dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .op_i, .override_mode_i, .override_steps_i,
    .out_valid_o, .out_stall_i, .led_bits_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  rspb_led_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i (in_stall_o), .op_i, .override_mode_i, .override_steps_i,
    .out_valid_i (out_valid_o), .out_stall_i, .led_bits_i (led_bits_o),
    .cfg_valid_i, .cfg_ready_i (cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o (fail_count), .pending_o (pending), .slow_steps_o (slow_steps)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short runs, now and then a long one
  function automatic int pick_run();
    return ($urandom_range(4) == 0) ? $urandom_range(30, 4) : $urandom_range(3, 1);
  endfunction

  function automatic logic [7:0] pick_mode();
    int r;
    r = $urandom_range(9);
    if (r < 2) return MODE_ALT;
    if (r < 6) return 8'($urandom_range(7));
    if (r < 7) return 8'($urandom_range(9, 8));
    return 8'($urandom_range(255));
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(2) == 0);
      stall_left <= pick_run();
    end
  end

  task automatic send_item(input logic op, input logic [7:0] mode, input logic [7:0] steps,
                           input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    override_mode_i <= mode;
    override_steps_i <= steps;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OP_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  // stop sending and wait until every led result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [2:0] mask, input logic [7:0] mode);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_TEAM_MASK;
    cfg_data_i <= {5'd0, mask};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_BLINK_MODE;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int gap;
    logic [7:0] steps;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes and override loads
    set_regs(3'd7, MODE_PHASE0);
    send_item(OP_LOAD, 8'hFF, 8'hFF, 0);
    send_item(OP_TICK, 8'hFF, 8'hFF, 0);
    send_item(OP_TICK, 8'h00, 8'h00, 0);
    send_item(OP_LOAD, 8'd9, 8'd0, 0);
    send_item(OP_LOAD, 8'd8, 8'd1, 1);
    send_item(OP_LOAD, MODE_ALT, 8'd2, 0);
    send_item(OP_TICK, 8'hAA, 8'h55, 2);
    send_item(OP_TICK, 8'h55, 8'hAA, 0);
    send_item(OP_LOAD, 8'h00, 8'h00, 0);
    send_item(OP_LOAD, MODE_STROBE, 8'h80, 3);
    for (int i = 0; i < 10; i++) begin
      send_item(OP_TICK, 8'($urandom), 8'($urandom), (i % 3 == 1) ? 1 : 0);
    end
    send_item(OP_LOAD, MODE_GLOW, 8'd3, 0);
    drain();

    for (int s = 0; s < 9; s++) begin
      if (s < 8) set_regs(mask_plan[s], mode_plan[s]);
      else set_regs(3'($urandom_range(7)), pick_mode());
      for (int n = 0; n < ItemsPerSetting; n++) begin
        if (n % 48 == 0) quiet <= ($urandom_range(3) == 0);
        gap = (quiet || $urandom_range(9) < 6) ? 0 : pick_run();
        if ($urandom_range(99) < 6) begin
          // short overrides so the pattern mode changes from step to step
          steps = ($urandom_range(15) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
          send_item(OP_LOAD, pick_mode(), steps, gap);
        end else begin
          send_item(OP_TICK, 8'($urandom), 8'($urandom), gap);
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("sent %0d ticks and %0d override loads under %0d register settings",
             ticks_sent, loads_sent, settings_used);
    $display("%0d slow pattern steps predicted, %0d mismatches", slow_steps, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
